>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RGB to HSV pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked out of reset only.
`define RTH_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Checked on every edge, reset included.
`define RTH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) \
		else $error(msg);

`else

`define RTH_ASSERT(lbl, clk, rst_n, prop, msg)
`define RTH_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

>>> rtl/rth_pkg.sv
// ----------------------------------------------------------------------------
// rth_pkg
// Types and constants of the RGB to HSV pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

	localparam int CHAN_W     = 8;
	localparam int HUE_W      = 15;
	localparam int HUE_QUO_W  = 12;                  // hue quotient <= 3840
	localparam int SAT_QUO_W  = 8;                   // saturation quotient <= 255
	localparam int HUE_NUM_W  = CHAN_W + HUE_QUO_W;  // 3840 * mag
	localparam int SAT_NUM_W  = CHAN_W + SAT_QUO_W;  // 255 * delta
	localparam int DIV_STAGES = 4;
	localparam int HUE_STEP   = HUE_QUO_W / DIV_STAGES;
	localparam int SAT_STEP   = SAT_QUO_W / DIV_STAGES;

	localparam logic [HUE_QUO_W-1:0] HUE_SECTOR = 12'd3840;
	localparam logic [HUE_W-1:0]     HUE_GREEN  = 15'd7680;
	localparam logic [HUE_W-1:0]     HUE_BLUE   = 15'd15360;
	localparam logic [HUE_W-1:0]     HUE_FULL   = 15'd23040;
	localparam logic [CHAN_W-1:0]    SAT_SCALE  = 8'd255;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [CHAN_W-1:0] saturation;
		logic [CHAN_W-1:0] brightness;
		logic [CHAN_W-1:0] alpha_out;
		logic              hue_undefined;
	} hsv_t;

	// After min/max and sector selection.
	typedef struct packed {
		logic [CHAN_W-1:0] mx;
		logic [CHAN_W-1:0] delta;
		logic [CHAN_W-1:0] mag;
		logic              neg;
		sector_t           sector;
		logic              undef;
		logic [CHAN_W-1:0] alpha;
	} class_t;

	// Running state of both long divisions.
	typedef struct packed {
		logic [HUE_NUM_W-1:0] hue_num;
		logic [CHAN_W-1:0]    hue_rem;
		logic [HUE_QUO_W-1:0] hue_quo;
		logic [SAT_NUM_W-1:0] sat_num;
		logic [CHAN_W-1:0]    sat_rem;
		logic [SAT_QUO_W-1:0] sat_quo;
		logic [CHAN_W-1:0]    mx;
		logic [CHAN_W-1:0]    delta;
		logic                 neg;
		sector_t              sector;
		logic                 undef;
		logic [CHAN_W-1:0]    alpha;
	} div_t;

	// One restoring step: shift in a numerator bit, subtract when it fits.
	// Returns {quotient bit, new remainder}.
	function automatic logic [CHAN_W:0] div_step(
		input logic [CHAN_W-1:0] rem,
		input logic              nbit,
		input logic [CHAN_W-1:0] dvs
	);
		logic [CHAN_W:0] trial;
		logic [CHAN_W:0] diff;
		trial = {rem, nbit};
		diff  = trial - {1'b0, dvs};
		if (trial >= {1'b0, dvs}) begin
			div_step = {1'b1, diff[CHAN_W-1:0]};
		end else begin
			div_step = {1'b0, trial[CHAN_W-1:0]};
		end
	endfunction

endpackage

>>> rtl/rth_stream_if.sv
// ----------------------------------------------------------------------------
// rth_stream_if
// Valid/ready stream channel with a typed payload.
// ----------------------------------------------------------------------------
interface rth_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rth_classify.sv
// ----------------------------------------------------------------------------
// rth_classify
// Stage 1: max, min, delta, sector and signed hue difference.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rth_classify (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  rth_pkg::pixel_t up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output rth_pkg::class_t dn_data
);
	import rth_pkg::*;

	logic              valid_s1;
	class_t            data_s1;
	class_t            nxt;
	logic [CHAN_W-1:0] mx;
	logic [CHAN_W-1:0] mn;
	logic [CHAN_W-1:0] pos;
	logic [CHAN_W-1:0] ngv;

	always_comb begin
		mx = up_data.red;
		mn = up_data.red;
		if (up_data.green > mx) mx = up_data.green;
		if (up_data.blue  > mx) mx = up_data.blue;
		if (up_data.green < mn) mn = up_data.green;
		if (up_data.blue  < mn) mn = up_data.blue;

		// ties resolve red first, then green
		if (up_data.red >= mx) begin
			pos        = up_data.green;
			ngv        = up_data.blue;
			nxt.sector = SECT_RED;
		end else if (up_data.green >= mx) begin
			pos        = up_data.blue;
			ngv        = up_data.red;
			nxt.sector = SECT_GREEN;
		end else begin
			pos        = up_data.red;
			ngv        = up_data.green;
			nxt.sector = SECT_BLUE;
		end

		nxt.mx    = mx;
		nxt.delta = mx - mn;
		nxt.neg   = (pos < ngv);
		nxt.mag   = (pos < ngv) ? (ngv - pos) : (pos - ngv);
		nxt.undef = (mx == mn);
		nxt.alpha = up_data.alpha;
	end

	assign up_ready = !valid_s1 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s1 <= nxt;
		end
	end

	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

	`RTH_ASSERT_ALWAYS(a_cls_rst_clear, clk, !arst_n |=> !dn_valid, "stage 1 valid after reset")
	`RTH_ASSERT(a_cls_mag, clk, arst_n, dn_valid |-> dn_data.mag <= dn_data.delta, "mag above delta")
endmodule

>>> rtl/rth_scale.sv
// ----------------------------------------------------------------------------
// rth_scale
// Stage 2: form both dividends and seed the long divisions.
// ----------------------------------------------------------------------------
module rth_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  rth_pkg::class_t up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output rth_pkg::div_t   dn_data
);
	import rth_pkg::*;

	logic                 valid_s2;
	div_t                 data_s2;
	div_t                 nxt;
	logic [HUE_NUM_W-1:0] hue_num;
	logic [SAT_NUM_W-1:0] sat_num;

	always_comb begin
		hue_num = HUE_NUM_W'(up_data.mag) * HUE_NUM_W'(HUE_SECTOR);
		sat_num = SAT_NUM_W'(up_data.delta) * SAT_NUM_W'(SAT_SCALE);

		nxt.hue_num = hue_num;
		// top bits are below the divisor since the quotient fits its width
		nxt.hue_rem = hue_num[HUE_NUM_W-1 -: CHAN_W];
		nxt.hue_quo = '0;
		nxt.sat_num = sat_num;
		nxt.sat_rem = sat_num[SAT_NUM_W-1 -: CHAN_W];
		nxt.sat_quo = '0;
		nxt.mx      = up_data.mx;
		nxt.delta   = up_data.delta;
		nxt.neg     = up_data.neg;
		nxt.sector  = up_data.sector;
		nxt.undef   = up_data.undef;
		nxt.alpha   = up_data.alpha;
	end

	assign up_ready = !valid_s2 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s2 <= nxt;
		end
	end

	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;
endmodule

>>> rtl/rth_divider.sv
// ----------------------------------------------------------------------------
// rth_divider
// Stages 3..6: pipelined restoring division of hue and saturation.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rth_divider (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  rth_pkg::div_t up_data,
	output logic          dn_valid,
	input  logic          dn_ready,
	output rth_pkg::div_t dn_data
);
	import rth_pkg::*;

	logic vld [0:DIV_STAGES];
	logic rdy [0:DIV_STAGES];
	div_t dat [0:DIV_STAGES];

	assign vld[0]          = up_valid;
	assign dat[0]          = up_data;
	assign up_ready        = rdy[0];
	assign rdy[DIV_STAGES] = dn_ready;
	assign dn_valid        = vld[DIV_STAGES];
	assign dn_data         = dat[DIV_STAGES];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		localparam int HUE_TOP = HUE_QUO_W - 1 - k * HUE_STEP;
		localparam int SAT_TOP = SAT_QUO_W - 1 - k * SAT_STEP;

		logic div_valid_sn;
		div_t div_data_sn;
		div_t nxt;

		always_comb begin
			logic [CHAN_W:0] st;
			nxt = dat[k];
			for (int j = 0; j < HUE_STEP; j++) begin
				st = div_step(nxt.hue_rem, nxt.hue_num[HUE_TOP - j], nxt.delta);
				nxt.hue_rem              = st[CHAN_W-1:0];
				nxt.hue_quo[HUE_TOP - j] = st[CHAN_W];
			end
			for (int j = 0; j < SAT_STEP; j++) begin
				st = div_step(nxt.sat_rem, nxt.sat_num[SAT_TOP - j], nxt.mx);
				nxt.sat_rem              = st[CHAN_W-1:0];
				nxt.sat_quo[SAT_TOP - j] = st[CHAN_W];
			end
		end

		assign rdy[k] = !div_valid_sn || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_valid_sn <= 1'b0;
			end else if (rdy[k]) begin
				div_valid_sn <= vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && vld[k]) begin
				div_data_sn <= nxt;
			end
		end

		assign vld[k+1] = div_valid_sn;
		assign dat[k+1] = div_data_sn;
	end

	`RTH_ASSERT(a_div_rem, clk, arst_n, dn_valid && !dn_data.undef |-> dn_data.hue_rem < dn_data.delta && dn_data.sat_rem < dn_data.mx, "remainder not below divisor")
endmodule

>>> rtl/rth_hue_wrap.sv
// ----------------------------------------------------------------------------
// rth_hue_wrap
// Stage 7: sector offset, hue wrap, gray override; output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rth_hue_wrap (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  rth_pkg::div_t up_data,
	output logic          dn_valid,
	input  logic          dn_ready,
	output rth_pkg::hsv_t dn_data
);
	import rth_pkg::*;

	logic           valid_s7;
	hsv_t           data_s7;
	hsv_t           nxt;
	logic [HUE_W-1:0] offset;
	logic [HUE_W-1:0] q;
	logic [HUE_W:0]   wrapped;

	always_comb begin
		case (up_data.sector)
			SECT_RED:   offset = '0;
			SECT_GREEN: offset = HUE_GREEN;
			SECT_BLUE:  offset = HUE_BLUE;
			default:    offset = '0;
		endcase

		q       = HUE_W'(up_data.hue_quo);
		wrapped = {1'b0, offset} + {1'b0, HUE_FULL} - {1'b0, q};

		if (up_data.undef) begin
			nxt.hue = '0;
		end else if (!up_data.neg) begin
			nxt.hue = offset + q;
		end else if (q > offset) begin
			nxt.hue = wrapped[HUE_W-1:0];
		end else begin
			nxt.hue = offset - q;
		end

		nxt.saturation    = up_data.undef ? '0 : up_data.sat_quo;
		nxt.brightness    = up_data.mx;
		nxt.alpha_out     = up_data.alpha;
		nxt.hue_undefined = up_data.undef;
	end

	assign up_ready = !valid_s7 || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (up_ready) begin
			valid_s7 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_s7 <= nxt;
		end
	end

	assign dn_valid = valid_s7;
	assign dn_data  = data_s7;

	`RTH_ASSERT(a_hue_range, clk, arst_n, dn_valid |-> dn_data.hue < HUE_FULL, "hue out of range")
	`RTH_ASSERT(a_gray_zero, clk, arst_n, dn_valid && dn_data.hue_undefined |-> dn_data.hue == '0 && dn_data.saturation == '0, "gray pixel with hue or saturation")
	`RTH_ASSERT(a_black_gray, clk, arst_n, dn_valid && dn_data.brightness == '0 |-> dn_data.hue_undefined, "black pixel not flagged gray")
endmodule

>>> rtl/rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// RGBA pixel to hexcone HSV, hue in 1/64 degree, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one pixel per clock while the output is not stalled and returns hue
// (0..23039), saturation floor(255*delta/max), brightness (max channel), alpha
// and a gray flag. The pipeline has one stage for min/max and sector, one for
// the two dividends, four for the two restoring dividers (3 hue quotient bits
// and 2 saturation bits per stage) and one for the sector offset and wrap.
// Every stage has its own valid bit and takes a new beat when it is empty or
// its successor moves, so bubbles close up and the input keeps flowing while
// a finished result waits at the output, until every stage is full.
module rgb_to_hsv_converter (
	input  logic              clk,
	input  logic              arst_n,
	rth_stream_if.sink        pixel,
	rth_stream_if.source      hsv
);
	import rth_pkg::*;

	logic   cls_valid;
	logic   cls_ready;
	class_t cls_data;
	logic   scl_valid;
	logic   scl_ready;
	div_t   scl_data;
	logic   div_valid;
	logic   div_ready;
	div_t   div_data;
	pixel_t pix_data;
	hsv_t   hsv_data;

	assign pix_data = pixel.data;

	rth_classify u_classify (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pixel.valid),
		.up_ready (pixel.ready),
		.up_data  (pix_data),
		.dn_valid (cls_valid),
		.dn_ready (cls_ready),
		.dn_data  (cls_data)
	);

	rth_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (cls_valid),
		.up_ready (cls_ready),
		.up_data  (cls_data),
		.dn_valid (scl_valid),
		.dn_ready (scl_ready),
		.dn_data  (scl_data)
	);

	rth_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (scl_valid),
		.up_ready (scl_ready),
		.up_data  (scl_data),
		.dn_valid (div_valid),
		.dn_ready (div_ready),
		.dn_data  (div_data)
	);

	rth_hue_wrap u_hue_wrap (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (div_valid),
		.up_ready (div_ready),
		.up_data  (div_data),
		.dn_valid (hsv.valid),
		.dn_ready (hsv.ready),
		.dn_data  (hsv_data)
	);

	assign hsv.data = hsv_data;
endmodule

>>> bench/tb_rgb_to_hsv_converter.sv
// ----------------------------------------------------------------------------
// tb_rgb_to_hsv_converter
// Self-checking bench for the RGBA to HSV pixel converter.
// ----------------------------------------------------------------------------
// A driver streams pixels from a pending queue. Every accepted beat is turned
// into an expected HSV result, and a monitor matches each output beat against
// the oldest of those. Gaps on the input and stalls on the output are random,
// with calm stretches, and the input is held back a few times until the
// pipeline has drained. Directed pixels come first: gray, primaries, ties
// between channels and hue wrap-around. After them come random pixels.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter;
	import rth_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_PIXELS = 1850;
	localparam int TAIL_CYCLES = 20;

	typedef struct {
		pixel_t px;
		bit     drain;   // hold this beat until every result is back
	} pending_pixel_t;

	logic clk;
	logic arst_n;

	rth_stream_if #(.T(pixel_t)) pixel_ch ();
	rth_stream_if #(.T(hsv_t))   hsv_ch ();

	rgb_to_hsv_converter DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_ch),
		.hsv    (hsv_ch)
	);

	pending_pixel_t pixel_pending[$];
	hsv_t           hsv_expected[$];

	int sent_count;
	int got_count;
	int mismatch_count = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int send_calm = 0;
	int recv_gap = 0;
	int recv_calm = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hexcone conversion, exact integer arithmetic.
	function automatic hsv_t convert_pixel(input pixel_t px);
		hsv_t    res;
		int      r, g, b, mx, mn, delta, pos, neg, mag, q, offset, hue;
		sector_t sect;
		r = px.red;
		g = px.green;
		b = px.blue;
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		res.brightness = mx[CHAN_W-1:0];
		res.alpha_out = px.alpha;
		if (delta == 0) begin
			res.hue = '0;
			res.saturation = '0;
			res.hue_undefined = 1'b1;
		end else begin
			res.hue_undefined = 1'b0;
			res.saturation = CHAN_W'((255 * delta) / mx);
			// ties resolve red first, then green
			if (r >= mx) sect = SECT_RED;
			else if (g >= mx) sect = SECT_GREEN;
			else sect = SECT_BLUE;
			case (sect)
				SECT_RED: begin
					pos = g;
					neg = b;
					offset = 0;
				end
				SECT_GREEN: begin
					pos = b;
					neg = r;
					offset = int'(HUE_GREEN);
				end
				default: begin
					pos = r;
					neg = g;
					offset = int'(HUE_BLUE);
				end
			endcase
			mag = (pos >= neg) ? pos - neg : neg - pos;
			q = (int'(HUE_SECTOR) * mag) / delta;
			if (pos >= neg) hue = offset + q;
			else if (q > offset) hue = offset + int'(HUE_FULL) - q;
			else hue = offset - q;
			res.hue = hue[HUE_W-1:0];
		end
		return res;
	endfunction

	// Mostly no gap, some short ones, a few long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic pixel_t make_pixel(input int r, input int g, input int b, input int a);
		pixel_t px;
		px.red = r[CHAN_W-1:0];
		px.green = g[CHAN_W-1:0];
		px.blue = b[CHAN_W-1:0];
		px.alpha = a[CHAN_W-1:0];
		return px;
	endfunction

	function automatic int pick_channel();
		int roll;
		roll = $urandom_range(0, 3);
		if (roll == 0) return 0;
		if (roll == 1) return 255;
		return $urandom_range(0, 255);
	endfunction

	// Uniform pixels, grays, two-channel ties and channel extremes.
	function automatic pixel_t random_pixel();
		int kind, hi, lo, odd, pair;
		int ch[3];
		kind = $urandom_range(0, 99);
		if (kind < 62) begin
			foreach (ch[i]) ch[i] = $urandom_range(0, 255);
		end else if (kind < 72) begin
			ch[0] = $urandom_range(0, 255);
			ch[1] = ch[0];
			ch[2] = ch[0];
		end else if (kind < 88) begin
			// two channels equal, either the largest or the smallest
			hi = $urandom_range(1, 255);
			lo = $urandom_range(0, hi - 1);
			pair = $urandom_range(0, 1);
			odd = $urandom_range(0, 2);
			foreach (ch[i]) ch[i] = pair ? hi : lo;
			ch[odd] = pair ? lo : hi;
		end else begin
			foreach (ch[i]) ch[i] = pick_channel();
		end
		return make_pixel(ch[0], ch[1], ch[2], $urandom_range(0, 255));
	endfunction

	task automatic queue_pixel(input pixel_t px, input bit drain);
		pending_pixel_t beat;
		beat.px = px;
		beat.drain = drain;
		pixel_pending.push_back(beat);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at result %0d: %s got %0d expected %0d", got_count, what, got, want);
		mismatch_count++;
	endtask

	// Driver
	always @(posedge clk or negedge arst_n) begin : drive_blk
		pending_pixel_t beat;
		logic           held;
		logic           next_valid;
		if (!arst_n) begin
			pixel_ch.valid <= 1'b0;
			pixel_ch.data <= '0;
			sent_count <= 0;
		end else begin
			held = pixel_ch.valid && !pixel_ch.ready;
			if (pixel_ch.valid && pixel_ch.ready) begin
				hsv_expected.push_back(convert_pixel(pixel_ch.data));
				sent_count <= sent_count + 1;
			end
			if (!held) begin
				next_valid = 1'b0;
				if (send_gap > 0) begin
					send_gap--;
				end else if (pixel_pending.size() > 0 &&
					(!pixel_pending[0].drain ||
					(!pixel_ch.valid && sent_count == got_count))) begin
					beat = pixel_pending.pop_front();
					pixel_ch.data <= beat.px;
					next_valid = 1'b1;
					if (send_calm > 0) begin
						send_calm--;
						send_gap = 0;
					end else begin
						send_gap = pick_gap();
						if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(30, 150);
					end
				end
				pixel_ch.valid <= next_valid;
			end
		end
	end

	// Monitor and output stalls
	always @(posedge clk or negedge arst_n) begin : watch_blk
		hsv_t want;
		hsv_t got;
		if (!arst_n) begin
			hsv_ch.ready <= 1'b0;
			got_count <= 0;
		end else begin
			if (hsv_ch.valid && hsv_ch.ready) begin
				got_count <= got_count + 1;
				got = hsv_ch.data;
				if (hsv_expected.size() == 0) begin
					report_mismatch("beat with nothing expected, hue", got.hue, 0);
				end else begin
					want = hsv_expected.pop_front();
					if (got.hue !== want.hue)
						report_mismatch("hue", got.hue, want.hue);
					if (got.saturation !== want.saturation)
						report_mismatch("saturation", got.saturation, want.saturation);
					if (got.brightness !== want.brightness)
						report_mismatch("brightness", got.brightness, want.brightness);
					if (got.alpha_out !== want.alpha_out)
						report_mismatch("alpha_out", got.alpha_out, want.alpha_out);
					if (got.hue_undefined !== want.hue_undefined)
						report_mismatch("hue_undefined", got.hue_undefined, want.hue_undefined);
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				hsv_ch.ready <= 1'b0;
			end else begin
				hsv_ch.ready <= 1'b1;
				if (recv_calm > 0) begin
					recv_calm--;
				end else begin
					recv_gap = pick_gap();
					if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(30, 150);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb_rgb_to_hsv_converter: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;

		// gray, black and white included
		queue_pixel(make_pixel(0, 0, 0, 0), 1'b0);
		queue_pixel(make_pixel(255, 255, 255, 255), 1'b0);
		queue_pixel(make_pixel(128, 128, 128, 77), 1'b0);
		queue_pixel(make_pixel(1, 1, 1, 254), 1'b0);
		// primaries
		queue_pixel(make_pixel(255, 0, 0, 255), 1'b0);
		queue_pixel(make_pixel(0, 255, 0, 0), 1'b0);
		queue_pixel(make_pixel(0, 0, 255, 170), 1'b0);
		// ties for the largest channel: red wins, then green
		queue_pixel(make_pixel(255, 255, 0, 85), 1'b0);
		queue_pixel(make_pixel(0, 255, 255, 1), 1'b0);
		queue_pixel(make_pixel(255, 0, 255, 128), 1'b0);
		queue_pixel(make_pixel(200, 200, 10, 3), 1'b0);
		// negative diff in every sector, red ones wrap around
		queue_pixel(make_pixel(255, 0, 1, 9), 1'b0);
		queue_pixel(make_pixel(200, 10, 190, 90), 1'b0);
		queue_pixel(make_pixel(100, 255, 0, 33), 1'b0);
		queue_pixel(make_pixel(255, 254, 0, 44), 1'b0);
		queue_pixel(make_pixel(254, 0, 255, 55), 1'b0);
		queue_pixel(make_pixel(10, 200, 255, 66), 1'b0);
		// small delta, small max
		queue_pixel(make_pixel(255, 254, 254, 12), 1'b0);
		queue_pixel(make_pixel(1, 0, 0, 200), 1'b0);
		queue_pixel(make_pixel(0, 1, 0, 201), 1'b0);
		queue_pixel(make_pixel(0, 0, 1, 202), 1'b0);
		queue_pixel(make_pixel(2, 1, 0, 203), 1'b0);

		for (int i = 0; i < RANDOM_PIXELS; i++)
			queue_pixel(random_pixel(), (i == 0 || i == 600 || i == 1200));

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_pending.size() != 0 || pixel_ch.valid) @(posedge clk);
		@(posedge clk);
		while (hsv_expected.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		while (hsv_expected.size() != 0) begin
			report_mismatch("missing result, hue", -1, hsv_expected[0].hue);
			void'(hsv_expected.pop_front());
		end

		if (mismatch_count == 0) begin
			$display("tb_rgb_to_hsv_converter: done, clean");
		end else begin
			$display("tb_rgb_to_hsv_converter: done, errors");
		end
		$finish;
	end

endmodule

>>> sim.f
+incdir+rtl
rtl/rth_pkg.sv
rtl/rth_stream_if.sv
rtl/rth_classify.sv
rtl/rth_scale.sv
rtl/rth_divider.sv
rtl/rth_hue_wrap.sv
rtl/rgb_to_hsv_converter.sv
bench/tb_rgb_to_hsv_converter.sv
